>>> design/sgf16mul_pkg.sv
package sgf16mul_pkg;

   localparam int unsigned NUM_SHARES = 4;
   localparam int unsigned NIB_W      = 4;
   localparam int unsigned GATES_W    = 9;
   localparam int unsigned CSR_IDX_W  = 3;

   typedef logic [NIB_W-1:0]     nib_type;
   typedef logic [GATES_W-1:0]   gates_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // register indexes of the configuration port
   localparam csr_idx_type CSR_SHARE0_GATES = 3'd0;
   localparam csr_idx_type CSR_SHARE1_GATES = 3'd1;
   localparam csr_idx_type CSR_SHARE2_GATES = 3'd2;
   localparam csr_idx_type CSR_SHARE3_GATES = 3'd3;

   // gating pattern after reset
   localparam gates_type SHARE0_GATES_RST = 9'd244;
   localparam gates_type SHARE1_GATES_RST = 9'd428;
   localparam gates_type SHARE2_GATES_RST = 9'd233;
   localparam gates_type SHARE3_GATES_RST = 9'd409;

   // bilinear product in the block's basis, bit 3 of each operand is a0/b0
   function automatic nib_type gf_mul(nib_type a, nib_type b);
      logic a0, a1, a2, a3, b0, b1, b2, b3;
      nib_type c;
      a0 = a[3]; a1 = a[2]; a2 = a[1]; a3 = a[0];
      b0 = b[3]; b1 = b[2]; b2 = b[1]; b3 = b[0];
      c[3] = (a0 & b0) ^ (a2 & b0) ^ (a3 & b0) ^ (a1 & b1) ^ (a2 & b1) ^ (a0 & b2)
           ^ (a1 & b2) ^ (a2 & b2) ^ (a3 & b2) ^ (a0 & b3) ^ (a2 & b3);
      c[2] = (a1 & b0) ^ (a2 & b0) ^ (a0 & b1) ^ (a1 & b1) ^ (a3 & b1) ^ (a0 & b2)
           ^ (a2 & b2) ^ (a1 & b3) ^ (a3 & b3);
      c[1] = (a0 & b0) ^ (a1 & b0) ^ (a2 & b0) ^ (a3 & b0) ^ (a0 & b1) ^ (a2 & b1)
           ^ (a0 & b2) ^ (a1 & b2) ^ (a2 & b2) ^ (a0 & b3) ^ (a3 & b3);
      c[0] = (a0 & b0) ^ (a2 & b0) ^ (a1 & b1) ^ (a3 & b1) ^ (a0 & b2) ^ (a3 & b2)
           ^ (a1 & b3) ^ (a2 & b3) ^ (a3 & b3);
      return c;
   endfunction

   // linear square-scalar map of the xor of both operands
   function automatic nib_type gf_sqsc(nib_type a, nib_type b);
      nib_type s;
      nib_type r;
      s = a ^ b;
      r[3] = s[2] ^ s[0];
      r[2] = s[3] ^ s[1];
      r[1] = s[1] ^ s[0];
      r[0] = s[0];
      return r;
   endfunction

   // one output share from the three input shares it may see
   function automatic nib_type share_out(gates_type g,
                                         nib_type xp, nib_type xq, nib_type xr,
                                         nib_type yp, nib_type yq, nib_type yr);
      nib_type u;
      nib_type v;
      nib_type r;
      u = (xp & {NIB_W{g[8]}}) ^ (xq & {NIB_W{g[7]}}) ^ (xr & {NIB_W{g[6]}});
      v = (yp & {NIB_W{g[5]}}) ^ (yq & {NIB_W{g[4]}}) ^ (yr & {NIB_W{g[3]}});
      r = (gf_sqsc(xp, yp) & {NIB_W{g[2]}})
        ^ (gf_sqsc(xq, yq) & {NIB_W{g[1]}})
        ^ (gf_sqsc(xr, yr) & {NIB_W{g[0]}});
      return gf_mul(u, v) ^ r;
   endfunction

endpackage

>>> design/shared_gf16_multiplier_four_shares_unit.sv
// Four-share masked GF(2^4) multiplier. Each output share is built only from the
// other three input shares of x and y, through configurable gating bits, one field
// product and gated square-scalar terms. A request is accepted every cycle unless
// req_stall is high; its response passes the input register, AND/XOR network and result
// register, and is delayed only while rsp_stall holds the result register. The gating
// registers are written through the csr port, which is always ready; writes to an
// index beyond share3_gates are dropped. Write them only while the block is empty.
module shared_gf16_multiplier_four_shares_unit (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sgf16mul_pkg::nib_type     req_x_share0,
   input  sgf16mul_pkg::nib_type     req_x_share1,
   input  sgf16mul_pkg::nib_type     req_x_share2,
   input  sgf16mul_pkg::nib_type     req_x_share3,
   input  sgf16mul_pkg::nib_type     req_y_share0,
   input  sgf16mul_pkg::nib_type     req_y_share1,
   input  sgf16mul_pkg::nib_type     req_y_share2,
   input  sgf16mul_pkg::nib_type     req_y_share3,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sgf16mul_pkg::nib_type     rsp_prod_share0,
   output sgf16mul_pkg::nib_type     rsp_prod_share1,
   output sgf16mul_pkg::nib_type     rsp_prod_share2,
   output sgf16mul_pkg::nib_type     rsp_prod_share3,
   // configuration write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  sgf16mul_pkg::csr_idx_type csr_index,
   input  sgf16mul_pkg::gates_type   csr_wdata
);

   sgf16mul_pkg::gates_type gates_ff [sgf16mul_pkg::NUM_SHARES];
   sgf16mul_pkg::nib_type   x_ff     [sgf16mul_pkg::NUM_SHARES];
   sgf16mul_pkg::nib_type   y_ff     [sgf16mul_pkg::NUM_SHARES];
   sgf16mul_pkg::nib_type   prod_ff  [sgf16mul_pkg::NUM_SHARES];
   sgf16mul_pkg::nib_type   prod_in  [sgf16mul_pkg::NUM_SHARES];
   logic                    in_vld_ff;
   logic                    out_vld_ff;
   logic                    in_load;
   logic                    out_load;

   // pipeline advance
   assign out_load  = !out_vld_ff || !rsp_stall;
   assign req_stall = in_vld_ff && !out_load;
   assign in_load   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // gating registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gates_ff[0] <= sgf16mul_pkg::SHARE0_GATES_RST;
         gates_ff[1] <= sgf16mul_pkg::SHARE1_GATES_RST;
         gates_ff[2] <= sgf16mul_pkg::SHARE2_GATES_RST;
         gates_ff[3] <= sgf16mul_pkg::SHARE3_GATES_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sgf16mul_pkg::CSR_SHARE0_GATES: gates_ff[0] <= csr_wdata;
            sgf16mul_pkg::CSR_SHARE1_GATES: gates_ff[1] <= csr_wdata;
            sgf16mul_pkg::CSR_SHARE2_GATES: gates_ff[2] <= csr_wdata;
            sgf16mul_pkg::CSR_SHARE3_GATES: gates_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid flags of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (in_load || out_load) begin
            in_vld_ff <= in_load;
         end
         if (out_load) begin
            out_vld_ff <= in_vld_ff;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (in_load) begin
         x_ff[0] <= req_x_share0;
         x_ff[1] <= req_x_share1;
         x_ff[2] <= req_x_share2;
         x_ff[3] <= req_x_share3;
         y_ff[0] <= req_y_share0;
         y_ff[1] <= req_y_share1;
         y_ff[2] <= req_y_share2;
         y_ff[3] <= req_y_share3;
      end
   end

   // each output share leaves out its own input share
   always_comb begin
      prod_in[0] = sgf16mul_pkg::share_out(gates_ff[0], x_ff[1], x_ff[2], x_ff[3],
                                           y_ff[1], y_ff[2], y_ff[3]);
      prod_in[1] = sgf16mul_pkg::share_out(gates_ff[1], x_ff[0], x_ff[2], x_ff[3],
                                           y_ff[0], y_ff[2], y_ff[3]);
      prod_in[2] = sgf16mul_pkg::share_out(gates_ff[2], x_ff[0], x_ff[1], x_ff[3],
                                           y_ff[0], y_ff[1], y_ff[3]);
      prod_in[3] = sgf16mul_pkg::share_out(gates_ff[3], x_ff[0], x_ff[1], x_ff[2],
                                           y_ff[0], y_ff[1], y_ff[2]);
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_load && in_vld_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_prod_share0 = prod_ff[0];
   assign rsp_prod_share1 = prod_ff[1];
   assign rsp_prod_share2 = prod_ff[2];
   assign rsp_prod_share3 = prod_ff[3];

endmodule

>>> design/sgf16mul_checker.sv
module sgf16mul_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input sgf16mul_pkg::nib_type rsp_prod_share0,
   input sgf16mul_pkg::nib_type rsp_prod_share1,
   input sgf16mul_pkg::nib_type rsp_prod_share2,
   input sgf16mul_pkg::nib_type rsp_prod_share3
);

   // nothing left over from before reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // requests are held back only by a blocked response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while response side is free");

   // every accepted request is followed by a valid response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("no response two cycles after request");

   // a held response keeps valid and data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_prod_share0)
         && $stable(rsp_prod_share1) && $stable(rsp_prod_share2)
         && $stable(rsp_prod_share3)))
      else $error("stalled response changed");

endmodule

bind shared_gf16_multiplier_four_shares_unit sgf16mul_checker u_sgf16mul_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_prod_share0 (rsp_prod_share0),
   .rsp_prod_share1 (rsp_prod_share1),
   .rsp_prod_share2 (rsp_prod_share2),
   .rsp_prod_share3 (rsp_prod_share3)
);

>>> bench/shared_gf16_multiplier_four_shares_unit_tb.sv
`timescale 1ns / 100ps

module shared_gf16_multiplier_four_shares_unit_tb;

   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned NUM_PHASES  = 8;
   localparam int unsigned PHASE_ITEMS = 210;

   typedef sgf16mul_pkg::nib_type [sgf16mul_pkg::NUM_SHARES-1:0] shares_type;

   typedef struct packed {
      shares_type x;
      shares_type y;
   } operands_type;

   // expected product shares, predicted from the gating registers
   class gf16_share_scoreboard;
      sgf16mul_pkg::gates_type share_gates [sgf16mul_pkg::NUM_SHARES];
      shares_type              expected_products [$];
      int unsigned             mismatches;
      int unsigned             products_checked;

      function new();
         share_gates[0]   = 9'd244;
         share_gates[1]   = 9'd428;
         share_gates[2]   = 9'd233;
         share_gates[3]   = 9'd409;
         mismatches       = 0;
         products_checked = 0;
      endfunction

      // out-of-range indexes leave every register alone
      function void write_gates(sgf16mul_pkg::csr_idx_type idx,
                                sgf16mul_pkg::gates_type value);
         if (idx <= sgf16mul_pkg::CSR_SHARE3_GATES)
            share_gates[idx] = value;
      endfunction

      // which a_i*b_j terms feed product bit 3-n (a0 is the operand msb)
      function logic [15:0] product_terms(int n);
         case (n)
            0:       return 16'h5F6D;
            1:       return 16'hA5B6;
            2:       return 16'h975F;
            default: return 16'hE9A5;
         endcase
      endfunction

      function sgf16mul_pkg::nib_type field_product(sgf16mul_pkg::nib_type a,
                                                    sgf16mul_pkg::nib_type b);
         logic [15:0]           terms;
         sgf16mul_pkg::nib_type p;
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               terms[i*4+j] = a[3-i] & b[3-j];
         for (int n = 0; n < 4; n++)
            p[3-n] = ^(terms & product_terms(n));
         return p;
      endfunction

      function sgf16mul_pkg::nib_type square_scalar(sgf16mul_pkg::nib_type a,
                                                    sgf16mul_pkg::nib_type b);
         sgf16mul_pkg::nib_type s;
         s = a ^ b;
         return {s[2] ^ s[0], s[3] ^ s[1], s[1] ^ s[0], s[0]};
      endfunction

      // share k sees only input shares other than k, in ascending order
      function shares_type predict(operands_type op);
         shares_type              prod;
         sgf16mul_pkg::nib_type   u;
         sgf16mul_pkg::nib_type   v;
         sgf16mul_pkg::nib_type   sq_sum;
         sgf16mul_pkg::gates_type g;
         int                      pos;
         for (int k = 0; k < sgf16mul_pkg::NUM_SHARES; k++) begin
            g      = share_gates[k];
            u      = '0;
            v      = '0;
            sq_sum = '0;
            pos    = 0;
            for (int i = 0; i < sgf16mul_pkg::NUM_SHARES; i++) begin
               if (i != k) begin
                  if (g[8-pos]) u ^= op.x[i];
                  if (g[5-pos]) v ^= op.y[i];
                  if (g[2-pos]) sq_sum ^= square_scalar(op.x[i], op.y[i]);
                  pos++;
               end
            end
            prod[k] = field_product(u, v) ^ sq_sum;
         end
         return prod;
      endfunction

      function void note_request(operands_type op);
         expected_products.push_back(predict(op));
      endfunction

      function void check_product(shares_type got);
         shares_type want;
         bit         bad;
         if (expected_products.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %h %h %h %h", got[0], got[1], got[2], got[3]);
            return;
         end
         want = expected_products.pop_front();
         products_checked++;
         bad = 1'b0;
         for (int k = 0; k < sgf16mul_pkg::NUM_SHARES; k++) begin
            if (got[k] !== want[k]) begin
               bad = 1'b1;
               if (mismatches < 10)
                  $display("response %0d prod_share%0d: expected %h, got %h",
                           products_checked, k, want[k], got[k]);
            end
         end
         if (bad)
            mismatches++;
      endfunction

      function int unsigned pending();
         return expected_products.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   shares_type                req_x;
   shares_type                req_y;
   logic                      rsp_valid;
   logic                      rsp_stall;
   shares_type                rsp_prod;
   logic                      csr_valid;
   logic                      csr_ready;
   sgf16mul_pkg::csr_idx_type csr_index;
   sgf16mul_pkg::gates_type   csr_wdata;

   gf16_share_scoreboard product_board;
   bit                   steady;
   bit                   hold_request;
   int unsigned          settings_used;

   shared_gf16_multiplier_four_shares_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_share0    (req_x[0]),
      .req_x_share1    (req_x[1]),
      .req_x_share2    (req_x[2]),
      .req_x_share3    (req_x[3]),
      .req_y_share0    (req_y[0]),
      .req_y_share1    (req_y[1]),
      .req_y_share2    (req_y[2]),
      .req_y_share3    (req_y[3]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prod_share0 (rsp_prod[0]),
      .rsp_prod_share1 (rsp_prod[1]),
      .rsp_prod_share2 (rsp_prod[2]),
      .rsp_prod_share3 (rsp_prod[3]),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   // response side stall: random, none while steady, one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall    = 1'b0;
         end else begin
            rsp_stall = !steady && ($urandom_range(99) < 35);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         product_board.check_product(rsp_prod);
   end

   function automatic sgf16mul_pkg::nib_type pick_nibble();
      case ($urandom_range(7))
         0:       return 4'h0;
         1:       return 4'hF;
         default: return sgf16mul_pkg::nib_type'($urandom_range(15));
      endcase
   endfunction

   function automatic operands_type random_operands();
      operands_type op;
      for (int k = 0; k < sgf16mul_pkg::NUM_SHARES; k++) begin
         op.x[k] = pick_nibble();
         op.y[k] = pick_nibble();
      end
      return op;
   endfunction

   // offer one request, optionally after a random gap, and wait for acceptance
   task automatic send_request(input operands_type op, input bit allow_gap);
      @(negedge clock);
      if (allow_gap && !steady && $urandom_range(99) < 35) begin
         req_valid = 1'b0;
         req_x     = shares_type'($urandom);
         req_y     = shares_type'($urandom);
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_x     = op.x;
      req_y     = op.y;
      do @(posedge clock); while (req_stall);
      product_board.note_request(op);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // let every response come back, then let the pipeline settle
   task automatic drain_products();
      while (product_board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input sgf16mul_pkg::csr_idx_type idx,
                            input sgf16mul_pkg::gates_type value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      product_board.write_gates(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // all four gating registers, then a write that must be dropped
   task automatic program_gates(input sgf16mul_pkg::gates_type g0,
                                input sgf16mul_pkg::gates_type g1,
                                input sgf16mul_pkg::gates_type g2,
                                input sgf16mul_pkg::gates_type g3);
      csr_write(sgf16mul_pkg::CSR_SHARE0_GATES, g0);
      csr_write(sgf16mul_pkg::CSR_SHARE1_GATES, g1);
      csr_write(sgf16mul_pkg::CSR_SHARE2_GATES, g2);
      csr_write(sgf16mul_pkg::CSR_SHARE3_GATES, g3);
      csr_write(sgf16mul_pkg::CSR_SHARE3_GATES
                   + sgf16mul_pkg::csr_idx_type'($urandom_range(1, 4)),
                sgf16mul_pkg::gates_type'($urandom));
      settings_used++;
   endtask

   // extremes, single shares, walking bits and repeated nibble patterns
   task automatic directed_requests();
      operands_type op;
      for (int n = 0; n < 16; n++) begin
         op = '0;
         case (n)
            0: ;
            1: op = '1;
            2: op.x = '1;
            3: op.y = '1;
            4, 5, 6, 7: begin
               op.x[n-4] = 4'hF;
               op.y[n-4] = 4'hF;
            end
            8, 9, 10, 11: begin
               for (int k = 0; k < sgf16mul_pkg::NUM_SHARES; k++) begin
                  op.x[k] = sgf16mul_pkg::nib_type'(1 << (n - 8));
                  op.y[k] = sgf16mul_pkg::nib_type'(8 >> (n - 8));
               end
            end
            12: begin
               op.x = {sgf16mul_pkg::NUM_SHARES{4'hA}};
               op.y = {sgf16mul_pkg::NUM_SHARES{4'h5}};
            end
            13: begin
               op.x = {sgf16mul_pkg::NUM_SHARES{4'h5}};
               op.y = {sgf16mul_pkg::NUM_SHARES{4'hA}};
            end
            14: op.x = {sgf16mul_pkg::NUM_SHARES{4'h9}};
            default: op.y = {sgf16mul_pkg::NUM_SHARES{4'h6}};
         endcase
         send_request(op, 1'b1);
      end
   endtask

   initial begin
      product_board = new();
      steady        = 1'b0;
      hold_request  = 1'b0;
      settings_used = 1;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_x         = '0;
      req_y         = '0;
      csr_valid     = 1'b0;
      csr_index     = sgf16mul_pkg::CSR_SHARE0_GATES;
      csr_wdata     = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // gating settings, only while the block is empty
         case (phase)
            0: ;
            1: program_gates('0, '0, '0, '0);
            2: program_gates('1, '1, '1, '1);
            3: program_gates(9'h100, 9'h020, 9'h004, 9'h1C0);
            4: program_gates(sgf16mul_pkg::SHARE0_GATES_RST, sgf16mul_pkg::SHARE1_GATES_RST,
                             sgf16mul_pkg::SHARE2_GATES_RST, sgf16mul_pkg::SHARE3_GATES_RST);
            default: program_gates(sgf16mul_pkg::gates_type'($urandom),
                                   sgf16mul_pkg::gates_type'($urandom),
                                   sgf16mul_pkg::gates_type'($urandom),
                                   sgf16mul_pkg::gates_type'($urandom));
         endcase

         if (phase == 0)
            directed_requests();
         steady = (phase == 3);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold while requests keep coming
            if (phase == 5 && n == 20) begin
               hold_request = 1'b1;
               repeat (24) send_request(random_operands(), 1'b0);
            end
            // sender pause until the block is empty
            if (phase == 6 && n == 100) begin
               release_request();
               drain_products();
            end
            send_request(random_operands(), 1'b1);
         end
         release_request();
         steady = 1'b0;
         drain_products();
      end

      repeat (8) @(posedge clock);
      $display("%0d responses checked under %0d gating settings", product_board.products_checked,
               settings_used);
      $display("covered zero/full gating, dropped register writes, long hold and back-to-back flow");
      if (product_board.mismatches == 0 && product_board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
